// ===== rtl/core/lspt_pkg.sv =====
// ============================================================================
// lspt_pkg: shared types and constants for the line sensor position tracker
// Holds the sensor count, derived widths, mode codes, the servo reload
// tables and the command and status words between controller and datapath.
// ============================================================================
package lspt_pkg;

    // The sensor count fixes the number of sample ports, so it is a constant.
    localparam int NUM_SENSORS      = 9;
    localparam int SAMPLE_BITS_DEF  = 10;

    localparam int IDX_W     = $clog2(NUM_SENSORS);
    localparam int CNT_W     = $clog2(NUM_SENSORS + 1);
    localparam int SUM_MAX   = NUM_SENSORS * (NUM_SENSORS - 1) / 2;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int POS_W     = 4;
    localparam int RELOAD_W  = 16;
    localparam int TABLE_LEN = 9;

    // Halves used for the split report.
    localparam int LEFT_END    = NUM_SENSORS / 2;
    localparam int RIGHT_START = (NUM_SENSORS - 1) / 2;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_BLACK  = 2'd1,
        MODE_WHITE  = 2'd2,
        MODE_START  = 2'd3
    } mode_t;

    localparam logic signed [1:0] DIR_LEFT  = -2'sd1;
    localparam logic signed [1:0] DIR_NONE  = 2'sd0;
    localparam logic signed [1:0] DIR_RIGHT = 2'sd1;

    typedef struct packed {
        logic load;    // capture an accepted word
        logic scan;    // process one sensor
        logic div;     // one restoring division step
        logic commit;  // move the result into the output register
    } lspt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_last;
    } lspt_status_t;

    function automatic logic [RELOAD_W-1:0] pulse_lut(input logic [POS_W-1:0] idx);
        logic [RELOAD_W-1:0] v;
        unique case (idx)
            4'd0:    v = 16'hFE24;
            4'd1:    v = 16'hFE3D;
            4'd2:    v = 16'hFE56;
            4'd3:    v = 16'hFE6F;
            4'd4:    v = 16'hFE88;
            4'd5:    v = 16'hFEA1;
            4'd6:    v = 16'hFEBA;
            4'd7:    v = 16'hFED3;
            default: v = 16'hFEEC;
        endcase
        return v;
    endfunction

    function automatic logic [RELOAD_W-1:0] gap_lut(input logic [POS_W-1:0] idx);
        logic [RELOAD_W-1:0] v;
        unique case (idx)
            4'd0:    v = 16'hED8A;
            4'd1:    v = 16'hEDA3;
            4'd2:    v = 16'hEDBC;
            4'd3:    v = 16'hEDD5;
            4'd4:    v = 16'hEDEE;
            4'd5:    v = 16'hEE07;
            4'd6:    v = 16'hEE20;
            4'd7:    v = 16'hEE39;
            default: v = 16'hEE52;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/lspt_datapath.sv =====
// ============================================================================
// lspt_datapath: sensor scan, centroid divider and output register
// Walks the sensors one per cycle, then divides the index sum by the hit
// count one quotient bit per cycle and registers the result word.
// ============================================================================
module lspt_datapath import lspt_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lspt_cmd_t              cmd,
    output lspt_status_t           status,
    input  logic [1:0]             in_mode,
    input  logic [SAMPLE_BITS-1:0] in_sensor [NUM_SENSORS],
    output logic                   out_traced,
    output logic [POS_W-1:0]       out_line_position,
    output logic [RELOAD_W-1:0]    out_pulse_reload,
    output logic [RELOAD_W-1:0]    out_gap_reload,
    output logic signed [1:0]      out_split_dir
);

    logic [SAMPLE_BITS-1:0] black_reg [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] white_reg [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] thr_reg   [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] samp_reg  [NUM_SENSORS];

    logic             race_reg;
    logic [POS_W-1:0] last_pos_reg;
    logic             trace_reg;
    logic             start_reg;
    logic [IDX_W-1:0] step_reg;
    logic [SUM_W-1:0] sq_reg;     // index sum, then quotient
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] right_reg;
    logic             nonzero_reg;

    logic [SAMPLE_BITS-1:0] cur_samp;
    logic [SAMPLE_BITS:0]   avg_sum;
    logic                   hit;
    logic [CNT_W:0]         rem_sh;
    logic                   q_bit;
    logic [CNT_W:0]         rem_sub;
    logic [POS_W-1:0]       pos;
    logic [POS_W-1:0]       tab_idx;
    logic signed [1:0]      dir;

    assign cur_samp = samp_reg[step_reg];
    assign avg_sum  = {1'b0, white_reg[step_reg]} + {1'b0, black_reg[step_reg]};
    assign hit      = trace_reg && (cur_samp > thr_reg[step_reg]);

    assign rem_sh  = {rem_reg, sq_reg[SUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, hits_reg};
    assign rem_sub = rem_sh - {1'b0, hits_reg};

    assign status.scan_last = step_reg == IDX_W'(NUM_SENSORS - 1);
    assign status.div_last  = step_reg == IDX_W'(SUM_W - 1);

    always_comb begin
        if (hits_reg == '0) begin
            pos = last_pos_reg;
        end else begin
            pos = POS_W'(sq_reg);
        end
        tab_idx = (pos < POS_W'(TABLE_LEN - 1)) ? pos : POS_W'(TABLE_LEN - 1);
        if (!nonzero_reg) begin
            dir = DIR_NONE;
        end else if (right_reg > left_reg) begin
            dir = DIR_RIGHT;
        end else if (right_reg < left_reg) begin
            dir = DIR_LEFT;
        end else begin
            dir = DIR_NONE;
        end
    end

    // Calibration and race state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            race_reg     <= 1'b0;
            last_pos_reg <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                black_reg[i] <= '0;
                white_reg[i] <= '0;
                thr_reg[i]   <= '0;
            end
        end else begin
            if (cmd.load && !race_reg && in_mode == MODE_BLACK) begin
                for (int i = 0; i < NUM_SENSORS; i++) black_reg[i] <= in_sensor[i];
            end
            if (cmd.load && !race_reg && in_mode == MODE_WHITE) begin
                for (int i = 0; i < NUM_SENSORS; i++) white_reg[i] <= in_sensor[i];
            end
            if (cmd.scan && start_reg) begin
                thr_reg[step_reg] <= avg_sum[SAMPLE_BITS:1];
                if (status.scan_last) begin
                    race_reg <= 1'b1;
                end
            end
            if (cmd.commit && trace_reg) begin
                last_pos_reg <= pos;
            end
        end
    end

    // Per-word working registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < NUM_SENSORS; i++) samp_reg[i] <= in_sensor[i];
            trace_reg   <= race_reg;
            start_reg   <= !race_reg && in_mode == MODE_START;
            step_reg    <= '0;
            sq_reg      <= '0;
            rem_reg     <= '0;
            hits_reg    <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            nonzero_reg <= 1'b1;
        end else if (cmd.scan) begin
            if (cur_samp == '0) begin
                nonzero_reg <= 1'b0;
            end
            if (hit) begin
                sq_reg   <= sq_reg + SUM_W'(step_reg);
                hits_reg <= hits_reg + CNT_W'(1);
                if (step_reg < IDX_W'(LEFT_END)) begin
                    left_reg <= left_reg + CNT_W'(1);
                end
                if (step_reg > IDX_W'(RIGHT_START)) begin
                    right_reg <= right_reg + CNT_W'(1);
                end
            end
            step_reg <= status.scan_last ? '0 : step_reg + IDX_W'(1);
        end else if (cmd.div) begin
            sq_reg   <= {sq_reg[SUM_W-2:0], q_bit};
            rem_reg  <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_reg <= step_reg + IDX_W'(1);
        end
    end

    // Output register; words outside the race are all zero.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_traced        <= trace_reg;
            out_line_position <= trace_reg ? pos : '0;
            out_pulse_reload  <= trace_reg ? pulse_lut(tab_idx) : '0;
            out_gap_reload    <= trace_reg ? gap_lut(tab_idx) : '0;
            out_split_dir     <= trace_reg ? dir : DIR_NONE;
        end
    end

endmodule

// ===== rtl/core/lspt_ctrl.sv =====
// ============================================================================
// lspt_ctrl: sequencing state machine for the position tracker
// Steps the datapath through load, scan, divide and commit, and owns the
// handshake of both channels.
// ============================================================================
module lspt_ctrl import lspt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output lspt_cmd_t    cmd,
    input  lspt_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_ready  = state_reg == ST_IDLE;
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.commit = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SCAN)
        else $error("accepted word did not start a scan");

    a_div_ends_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && status.div_last |=> state_reg == ST_DONE)
        else $error("division did not finish into the done state");

    a_commit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> state_reg == ST_DONE && (!out_valid_reg || m_ready))
        else $error("result committed over a waiting word");

    a_pending_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready && !cmd.commit |=> out_valid_reg)
        else $error("pending result word dropped");

endmodule

// ===== rtl/core/line_sensor_position_tracker_top.sv =====
// ============================================================================
// line_sensor_position_tracker_top: line sensor position tracker
// Calibrates per-sensor thresholds, then turns each scan of the sensor row
// into a line position, servo timer reloads and a split direction.
// ============================================================================
// Usage notes.
// The input channel (s_valid/s_ready) carries one word per sensor scan: a
// mode and one sample per sensor. Before the race, store-black and
// store-white words latch calibration levels and a start word derives the
// thresholds and enables racing. Every accepted word yields exactly one
// result word on the m_ channel (m_valid/m_ready); outside the race that
// word is all zero, during the race m_traced is set.
// From acceptance the block scans one sensor per cycle, then runs the
// centroid division one quotient bit per cycle, then commits the result
// to the output register once it is free. One word is in flight at a
// time, so a new word is taken only after the previous one is committed.
// The result sits in its own output register, so s_ready returns while a
// finished word still waits for m_ready. If the receiver stalls, the next
// result waits in the datapath and the block takes no new word until the
// output register frees. Reset (aresetn low at a clock edge) clears the
// calibration levels, thresholds, held position and race flag.
// ============================================================================
module line_sensor_position_tracker_top import lspt_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_mode,
    input  logic [SAMPLE_BITS-1:0] s_sensor_0,
    input  logic [SAMPLE_BITS-1:0] s_sensor_1,
    input  logic [SAMPLE_BITS-1:0] s_sensor_2,
    input  logic [SAMPLE_BITS-1:0] s_sensor_3,
    input  logic [SAMPLE_BITS-1:0] s_sensor_4,
    input  logic [SAMPLE_BITS-1:0] s_sensor_5,
    input  logic [SAMPLE_BITS-1:0] s_sensor_6,
    input  logic [SAMPLE_BITS-1:0] s_sensor_7,
    input  logic [SAMPLE_BITS-1:0] s_sensor_8,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_traced,
    output logic [POS_W-1:0]       m_line_position,
    output logic [RELOAD_W-1:0]    m_pulse_reload,
    output logic [RELOAD_W-1:0]    m_gap_reload,
    output logic signed [1:0]      m_split_dir
);

    lspt_cmd_t              cmd;
    lspt_status_t           status;
    logic [SAMPLE_BITS-1:0] sensors [NUM_SENSORS];

    // Gather the sample ports into one row, leftmost sensor first.
    assign sensors[0] = s_sensor_0;
    assign sensors[1] = s_sensor_1;
    assign sensors[2] = s_sensor_2;
    assign sensors[3] = s_sensor_3;
    assign sensors[4] = s_sensor_4;
    assign sensors[5] = s_sensor_5;
    assign sensors[6] = s_sensor_6;
    assign sensors[7] = s_sensor_7;
    assign sensors[8] = s_sensor_8;

    lspt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    lspt_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_mode           (s_mode),
        .in_sensor         (sensors),
        .out_traced        (m_traced),
        .out_line_position (m_line_position),
        .out_pulse_reload  (m_pulse_reload),
        .out_gap_reload    (m_gap_reload),
        .out_split_dir     (m_split_dir)
    );

endmodule

// ===== dv/line_sensor_position_tracker_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// line_sensor_position_tracker_top_test: self-checking bench for the tracker
// Drives calibration, race start and race scans through the input channel,
// mirrors the calibration and tracking state in a local predictor and checks
// every result word on the output channel field by field, in order.
// ============================================================================
module line_sensor_position_tracker_top_test;
    import lspt_pkg::*;

    localparam int SMP_W = SAMPLE_BITS_DEF;

    typedef logic [NUM_SENSORS-1:0][SMP_W-1:0] scan_t;

    // One expected result word, laid out like the output ports.
    typedef struct packed {
        logic                  traced;
        logic [POS_W-1:0]      pos;
        logic [RELOAD_W-1:0]   pulse;
        logic [RELOAD_W-1:0]   gap;
        logic signed [1:0]     dir;
    } trace_word_t;

    // Servo reload tables, entry 0 in the low bits.
    localparam logic [TABLE_LEN-1:0][RELOAD_W-1:0] PULSE_TABLE = {
        16'hFEEC, 16'hFED3, 16'hFEBA, 16'hFEA1, 16'hFE88,
        16'hFE6F, 16'hFE56, 16'hFE3D, 16'hFE24
    };
    localparam logic [TABLE_LEN-1:0][RELOAD_W-1:0] GAP_TABLE = {
        16'hEE52, 16'hEE39, 16'hEE20, 16'hEE07, 16'hEDEE,
        16'hEDD5, 16'hEDBC, 16'hEDA3, 16'hED8A
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // Input channel, driven at the falling edge.
    logic  s_valid = 1'b0;
    logic  s_ready;
    mode_t s_mode = MODE_SAMPLE;
    scan_t tx_scan = '0;

    // Output channel.
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_traced;
    logic [POS_W-1:0]    m_line_position;
    logic [RELOAD_W-1:0] m_pulse_reload;
    logic [RELOAD_W-1:0] m_gap_reload;
    logic signed [1:0]   m_split_dir;

    // Mirror of the block's state, updated as words are accepted.
    scan_t            black_lv = '0;
    scan_t            white_lv = '0;
    scan_t            thresh = '0;
    logic [POS_W-1:0] held_pos = '0;
    bit               racing = 1'b0;

    trace_word_t trace_q[$];
    int          error_count = 0;

    // Random idling on both sides is enabled while this is set.
    bit idling = 1'b0;
    // Set for a long stretch while the receiver refuses every word.
    bit rx_hold = 1'b0;
    int rx_stall = 0;

    line_sensor_position_tracker_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_sensor_0      (tx_scan[0]),
        .s_sensor_1      (tx_scan[1]),
        .s_sensor_2      (tx_scan[2]),
        .s_sensor_3      (tx_scan[3]),
        .s_sensor_4      (tx_scan[4]),
        .s_sensor_5      (tx_scan[5]),
        .s_sensor_6      (tx_scan[6]),
        .s_sensor_7      (tx_scan[7]),
        .s_sensor_8      (tx_scan[8]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_traced        (m_traced),
        .m_line_position (m_line_position),
        .m_pulse_reload  (m_pulse_reload),
        .m_gap_reload    (m_gap_reload),
        .m_split_dir     (m_split_dir)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the result word for one accepted input word and advances
    // the mirrored state the same way the block does.
    function automatic trace_word_t track_line(input mode_t mode, input scan_t scan);
        trace_word_t      w;
        int               sum;
        int               count;
        int               left;
        int               right;
        bit               all_lit;
        logic [POS_W-1:0] pos;
        int               idx;
        w = '0;
        if (!racing) begin
            // Calibration phase: the result word is all zero.
            case (mode)
                MODE_BLACK: black_lv = scan;
                MODE_WHITE: white_lv = scan;
                MODE_START: begin
                    for (int i = 0; i < NUM_SENSORS; i++) begin
                        thresh[i] = SMP_W'(({1'b0, white_lv[i]} + {1'b0, black_lv[i]}) >> 1);
                    end
                    racing = 1'b1;
                end
                default: ;
            endcase
            return w;
        end
        // During the race every word is traced and the mode is ignored.
        sum = 0;
        count = 0;
        left = 0;
        right = 0;
        all_lit = 1'b1;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (scan[i] == '0)
                all_lit = 1'b0;
            if (scan[i] > thresh[i]) begin
                sum += i;
                count++;
                if (i < LEFT_END)
                    left++;
                if (i > RIGHT_START)
                    right++;
            end
        end
        // With no sensor over its threshold the previous position holds.
        pos = (count == 0) ? held_pos : POS_W'(sum / count);
        held_pos = pos;
        idx = (pos < TABLE_LEN - 1) ? int'(pos) : TABLE_LEN - 1;
        w.traced = 1'b1;
        w.pos = pos;
        w.pulse = PULSE_TABLE[idx];
        w.gap = GAP_TABLE[idx];
        w.dir = DIR_NONE;
        // The split is only judged when no sample reads zero.
        if (all_lit) begin
            if (right > left)
                w.dir = DIR_RIGHT;
            else if (right < left)
                w.dir = DIR_LEFT;
        end
        return w;
    endfunction

    function automatic scan_t fill(input logic [SMP_W-1:0] v);
        scan_t s;
        for (int i = 0; i < NUM_SENSORS; i++)
            s[i] = v;
        return s;
    endfunction

    // Sensors flagged in lit sit one count over their threshold, the rest
    // sit exactly on it, which does not count as over.
    function automatic scan_t level_scan(input logic [NUM_SENSORS-1:0] lit);
        scan_t s;
        for (int i = 0; i < NUM_SENSORS; i++)
            s[i] = lit[i] ? thresh[i] + 1'b1 : thresh[i];
        return s;
    endfunction

    // Race scan: mostly samples placed on a chosen side of each threshold,
    // now and then a zero, and sometimes fully random samples.
    function automatic scan_t random_race_scan();
        scan_t s;
        bit    wild;
        wild = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (wild)
                s[i] = SMP_W'($urandom);
            else if ($urandom_range(0, 15) == 0)
                s[i] = '0;
            else if ($urandom_range(0, 1) == 1)
                s[i] = SMP_W'($urandom_range(int'(thresh[i]) + 1, (1 << SMP_W) - 1));
            else
                s[i] = SMP_W'($urandom_range(1, int'(thresh[i])));
        end
        return s;
    endfunction

    function automatic mode_t random_race_mode();
        if ($urandom_range(0, 7) < 5)
            return MODE_SAMPLE;
        return mode_t'($urandom_range(1, 3));
    endfunction

    // Offers one word, waits for it to be taken and records its result.
    task automatic send_scan(input mode_t mode, input scan_t scan);
        @(negedge aclk);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        tx_scan <= scan;
        do @(posedge aclk); while (!s_ready);
        trace_q.push_back(track_line(mode, scan));
    endtask

    task automatic release_inputs();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_for_traces();
        while (trace_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Receiver: random stall bursts while idling is set, or a long
    // refusal while rx_hold is set.
    always @(negedge aclk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            rx_stall = $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Checker: each word taken from the output is matched against the
    // oldest expectation.
    always @(posedge aclk) begin
        trace_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (trace_q.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_line_position), 32'd0);
            end else begin
                w = trace_q.pop_front();
                if (m_traced !== w.traced)
                    report_mismatch("traced", 32'(m_traced), 32'(w.traced));
                if (m_line_position !== w.pos)
                    report_mismatch("line_position", 32'(m_line_position), 32'(w.pos));
                if (m_pulse_reload !== w.pulse)
                    report_mismatch("pulse_reload", 32'(m_pulse_reload), 32'(w.pulse));
                if (m_gap_reload !== w.gap)
                    report_mismatch("gap_reload", 32'(m_gap_reload), 32'(w.gap));
                if (m_split_dir !== w.dir)
                    report_mismatch("split_dir", 32'(unsigned'(m_split_dir)),
                                    32'(unsigned'(w.dir)));
            end
        end
    end

    // Extremes of the samples in every calibration mode before the race.
    task automatic test_calibration_directed();
        send_scan(MODE_SAMPLE, fill('1));
        send_scan(MODE_BLACK, fill('0));
        send_scan(MODE_WHITE, fill('1));
        send_scan(MODE_BLACK, fill(10'h2AA));
        send_scan(MODE_WHITE, fill(10'h155));
        send_scan(MODE_SAMPLE, fill('0));
    endtask

    // Random calibration traffic, then final levels that leave every
    // threshold well inside the sample range.
    task automatic test_calibration_random();
        scan_t s;
        idling = 1'b1;
        repeat (30) begin
            for (int i = 0; i < NUM_SENSORS; i++)
                s[i] = SMP_W'($urandom);
            send_scan(mode_t'($urandom_range(0, 2)), s);
        end
        for (int i = 0; i < NUM_SENSORS; i++)
            s[i] = SMP_W'($urandom_range(0, 600));
        send_scan(MODE_BLACK, s);
        for (int i = 0; i < NUM_SENSORS; i++)
            s[i] = SMP_W'($urandom_range(300, 1023));
        send_scan(MODE_WHITE, s);
    endtask

    task automatic test_race_start();
        send_scan(MODE_START, fill(SMP_W'($urandom)));
    endtask

    // Hand-picked race scans: held position, truncation, both split
    // directions, a zero sample that cancels the split, and calibration
    // or start words that the race ignores.
    task automatic test_race_directed();
        scan_t s;
        idling = 1'b0;
        send_scan(MODE_SAMPLE, fill('0));
        send_scan(MODE_SAMPLE, fill('1));
        send_scan(MODE_SAMPLE, level_scan(9'b000000001));
        send_scan(MODE_SAMPLE, level_scan(9'b100000000));
        send_scan(MODE_SAMPLE, level_scan(9'b000000000));
        send_scan(MODE_SAMPLE, level_scan(9'b000001111));
        send_scan(MODE_SAMPLE, level_scan(9'b111100000));
        send_scan(MODE_SAMPLE, level_scan(9'b000010000));
        send_scan(MODE_SAMPLE, level_scan(9'b100000001));
        send_scan(MODE_SAMPLE, level_scan(9'b110000000));
        send_scan(MODE_SAMPLE, level_scan(9'b000000011));
        s = level_scan(9'b100000000);
        s[0] = '0;
        send_scan(MODE_SAMPLE, s);
        send_scan(MODE_BLACK, fill('0));
        send_scan(MODE_WHITE, fill('1));
        send_scan(MODE_START, level_scan(9'b000100000));
    endtask

    // Random race scans, with idling switched on and off in stretches.
    task automatic test_race_random();
        for (int n = 0; n < 300; n++) begin
            if (n % 50 == 0)
                idling = ($urandom_range(0, 3) != 0);
            send_scan(random_race_mode(), random_race_scan());
        end
    endtask

    // The receiver refuses words for a long stretch while the sender keeps
    // offering, so the output register and the datapath both fill up.
    task automatic test_backpressure();
        idling = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (12)
            send_scan(random_race_mode(), random_race_scan());
    endtask

    // The sender goes quiet until every outstanding word has come back.
    task automatic test_drain_pause();
        idling = 1'b1;
        repeat (20)
            send_scan(random_race_mode(), random_race_scan());
        release_inputs();
        wait_for_traces();
        repeat (20)
            send_scan(random_race_mode(), random_race_scan());
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_race_steady();
        idling = 1'b0;
        repeat (80)
            send_scan(random_race_mode(), random_race_scan());
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_calibration_directed();
        test_calibration_random();
        test_race_start();
        test_race_directed();
        test_race_random();
        test_backpressure();
        test_drain_pause();
        test_race_steady();
        release_inputs();
        wait_for_traces();
        // Let any stray word show up before the verdict.
        repeat (40) @(posedge aclk);
        if (error_count == 0 && trace_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== line_sensor_position_tracker_top.f =====
rtl/core/lspt_pkg.sv
rtl/core/lspt_datapath.sv
rtl/core/lspt_ctrl.sv
rtl/core/line_sensor_position_tracker_top.sv
dv/line_sensor_position_tracker_top_test.sv
